// ----- rtl/core/simplex_jacobian_determinant_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef SIMPLEX_JACOBIAN_DETERMINANT_UNIT_DEFINES_SVH
`define SIMPLEX_JACOBIAN_DETERMINANT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define SJD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sjd check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define SJD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sjd check failed");

`endif

// ----- rtl/core/sjd_pkg.sv -----
// Shared constants for the simplex Jacobian determinant unit.
`default_nettype none
package sjd_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int DET_W   = 53;
  localparam int RECIP_W = 64;
  localparam int QUO_W   = 63;  // dividend 2^62 has 63 bits
  localparam int DIV_STEPS = 63;
  localparam int DIM_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [DIM_W-1:0] DIM_TRI = 2'd2;
  localparam logic [DIM_W-1:0] DIM_TET = 2'd3;
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_TRI;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_SINGULAR = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_DIM  = 2'd2;
endpackage
`default_nettype wire

// ----- rtl/core/simplex_jacobian_determinant_unit.sv -----
// Top level: pipelined simplex Jacobian determinant, reciprocal and measure.
// Pipeline: edge differences, cofactors and products, then the bit-per-stage
// reciprocal divider (measure /6 multiplies by 1/3 in its last 3 stages), 1 output reg.
// Throughput: one element per cycle; busy is always low.
// Reset: rst (synchronous) clears all valid bits and sets dimension to 2.
`default_nettype none
module simplex_jacobian_determinant_unit #(
  parameter int COORD_WIDTH = sjd_pkg::COORD_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [sjd_pkg::DIM_W-1:0] cfg_data,
  input  wire logic start,
  output logic      busy,
  input  wire logic signed [15:0] v1_x, v1_y, v1_z,
  input  wire logic signed [15:0] v2_x, v2_y, v2_z,
  input  wire logic signed [15:0] v3_x, v3_y, v3_z,
  input  wire logic signed [15:0] v4_x, v4_y, v4_z,
  output logic      done,
  output logic signed [sjd_pkg::DET_W-1:0]   determinant,
  output logic signed [sjd_pkg::RECIP_W-1:0] reciprocal,
  output logic signed [sjd_pkg::DET_W-1:0]   measure,
  output logic [sjd_pkg::STAT_W-1:0]         status
);
  localparam int W   = COORD_WIDTH;
  localparam int EW1 = W + 1;           // edge component
  localparam int CW  = 2 * W + 3;       // cofactor
  localparam int PW  = 3 * W + 4;       // edge times cofactor
  localparam int SW  = 3 * W + 6;       // sum of three products
  localparam int XW  = (SW > sjd_pkg::DET_W) ? SW : sjd_pkg::DET_W;
  localparam int DW  = sjd_pkg::DET_W;
  localparam int QW  = sjd_pkg::QUO_W;
  localparam int NS  = sjd_pkg::DIV_STEPS;
  localparam int RW  = DW + 1;          // divider remainder
  localparam int HW  = DW - 3;          // mag >> 1 stays below 2^50
  localparam int HH  = HW / 2;          // partial product operand width
  // (2^51 + 1) / 3: floor(h * RECIP3 / 2^51) == floor(h / 3) for h < 2^50
  localparam logic [HW-1:0] RECIP3 = HW'(((64'd1 << (HW + 1)) + 64'd1) / 64'd3);

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration register
  logic [sjd_pkg::DIM_W-1:0] dimension;
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= sjd_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dimension <= cfg_data;
    end
  end

  // stage 1: edge vectors from vertex 1
  logic signed [W-1:0] c1x, c1y, c1z, c2x, c2y, c2z, c3x, c3y, c3z, c4x, c4y, c4z;
  assign c1x = v1_x[W-1:0]; assign c1y = v1_y[W-1:0]; assign c1z = v1_z[W-1:0];
  assign c2x = v2_x[W-1:0]; assign c2y = v2_y[W-1:0]; assign c2z = v2_z[W-1:0];
  assign c3x = v3_x[W-1:0]; assign c3y = v3_y[W-1:0]; assign c3z = v3_z[W-1:0];
  assign c4x = v4_x[W-1:0]; assign c4y = v4_y[W-1:0]; assign c4z = v4_z[W-1:0];

  logic s1_vld;
  logic [sjd_pkg::DIM_W-1:0] s1_dim;
  logic signed [EW1-1:0] ax, ay, az, bx, by, bz, dx, dy, dz;
  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= start && !busy;
  end
  always_ff @(posedge clk) begin
    s1_dim <= dimension;
    ax <= EW1'(c2x) - EW1'(c1x); ay <= EW1'(c2y) - EW1'(c1y); az <= EW1'(c2z) - EW1'(c1z);
    bx <= EW1'(c3x) - EW1'(c1x); by <= EW1'(c3y) - EW1'(c1y); bz <= EW1'(c3z) - EW1'(c1z);
    dx <= EW1'(c4x) - EW1'(c1x); dy <= EW1'(c4y) - EW1'(c1y); dz <= EW1'(c4z) - EW1'(c1z);
  end

  // stage 2: 2x2 minors
  logic s2_vld;
  logic [sjd_pkg::DIM_W-1:0] s2_dim;
  logic signed [EW1-1:0] s2_ax, s2_ay, s2_az;
  logic signed [CW-1:0] m1, m2, m3, d2;
  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else     s2_vld <= s1_vld;
  end
  always_ff @(posedge clk) begin
    s2_dim <= s1_dim;
    s2_ax <= ax; s2_ay <= ay; s2_az <= az;
    m1 <= CW'(by * dz) - CW'(bz * dy);
    m2 <= CW'(bx * dz) - CW'(bz * dx);
    m3 <= CW'(bx * dy) - CW'(by * dx);
    d2 <= CW'(ax * by) - CW'(bx * ay);
  end

  // stage 3: edge times minor
  logic s3_vld;
  logic [sjd_pkg::DIM_W-1:0] s3_dim;
  logic signed [PW-1:0] p1, p2, p3;
  logic signed [CW-1:0] s3_d2;
  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else     s3_vld <= s2_vld;
  end
  always_ff @(posedge clk) begin
    s3_dim <= s2_dim;
    s3_d2 <= d2;
    p1 <= PW'(s2_ax) * PW'(m1);
    p2 <= PW'(s2_ay) * PW'(m2);
    p3 <= PW'(s2_az) * PW'(m3);
  end

  // stage 4: select determinant, sign, magnitude, status
  logic signed [XW-1:0] det3_x, det_x;
  logic signed [DW-1:0] det_sel;
  logic [DW-1:0] mag_sel;
  logic [sjd_pkg::STAT_W-1:0] stat_sel;
  always_comb begin
    det3_x = XW'(p1) - XW'(p2) + XW'(p3);
    stat_sel = sjd_pkg::ST_OK;
    if (s3_dim == sjd_pkg::DIM_TRI) begin
      det_x = XW'(s3_d2);
    end else if (s3_dim == sjd_pkg::DIM_TET) begin
      det_x = det3_x;
    end else begin
      det_x = '0;
      stat_sel = sjd_pkg::ST_BAD_DIM;
    end
    det_sel = det_x[DW-1:0];
    mag_sel = det_sel[DW-1] ? DW'(-det_sel) : DW'(det_sel);
    if (stat_sel == sjd_pkg::ST_OK && det_sel == '0) stat_sel = sjd_pkg::ST_SINGULAR;
  end

  // divider pipeline: 2^62 / mag, one quotient bit per stage
  logic                       pv   [0:NS];
  logic                       p3d  [0:NS];
  logic signed [DW-1:0]       pdet [0:NS];
  logic [DW-1:0]              pmag [0:NS];
  logic [sjd_pkg::STAT_W-1:0] pst  [0:NS];
  logic [RW-1:0]              prr  [0:NS];
  logic [QW-1:0]              pq   [0:NS];

  always_ff @(posedge clk) begin
    if (rst) pv[0] <= 1'b0;
    else     pv[0] <= s3_vld;
  end
  always_ff @(posedge clk) begin
    p3d[0]  <= (s3_dim == sjd_pkg::DIM_TET);
    pdet[0] <= det_sel;
    pmag[0] <= mag_sel;
    pst[0]  <= stat_sel;
    prr[0]  <= '0;
    pq[0]   <= '0;
  end

  for (genvar i = 0; i < NS; i++) begin : g_div
    logic          nb;
    logic [RW:0]   t;
    logic          ge;
    always_comb begin
      nb  = (i == 0);
      t   = {prr[i], nb};
      ge  = (t >= (RW+1)'(pmag[i]));
    end
    always_ff @(posedge clk) begin
      if (rst) pv[i+1] <= 1'b0;
      else     pv[i+1] <= pv[i];
    end
    always_ff @(posedge clk) begin
      p3d[i+1]  <= p3d[i];
      pdet[i+1] <= pdet[i];
      pmag[i+1] <= pmag[i];
      pst[i+1]  <= pst[i];
      prr[i+1]  <= ge ? RW'(t - (RW+1)'(pmag[i])) : RW'(t);
      pq[i+1]   <= {pq[i][QW-2:0], ge};
    end
  end

  // measure /6 as (mag >> 1) / 3, reciprocal multiply over the last 3 stages
  logic [HW-1:0]   half_mag;
  logic [2*HH-1:0] m6_ll, m6_lh, m6_hl, m6_hh, m6_ll2, m6_hh2;
  logic [2*HH:0]   m6_mid;
  logic [2*HW-1:0] m6_sum;
  logic [HW-2:0]   q6;
  assign half_mag = pmag[NS-3][HW:1];
  assign m6_sum = {m6_hh2, m6_ll2} + ((2*HW)'(m6_mid) << HH);
  always_ff @(posedge clk) begin
    // 25x25 partial products
    m6_ll <= (2*HH)'(half_mag[HH-1:0]) * (2*HH)'(RECIP3[HH-1:0]);
    m6_lh <= (2*HH)'(half_mag[HH-1:0]) * (2*HH)'(RECIP3[HW-1:HH]);
    m6_hl <= (2*HH)'(half_mag[HW-1:HH]) * (2*HH)'(RECIP3[HH-1:0]);
    m6_hh <= (2*HH)'(half_mag[HW-1:HH]) * (2*HH)'(RECIP3[HW-1:HH]);
    // middle terms
    m6_mid <= (2*HH+1)'(m6_lh) + (2*HH+1)'(m6_hl);
    m6_ll2 <= m6_ll;
    m6_hh2 <= m6_hh;
    // final sum, quotient lands with the last divider stage
    q6 <= m6_sum[2*HW-1:HW+1];
  end

  // output register
  logic neg_o;
  assign neg_o = pdet[NS][DW-1];
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= pv[NS];
  end
  always_ff @(posedge clk) begin
    determinant <= pdet[NS];
    status      <= pst[NS];
    if (pst[NS] == sjd_pkg::ST_OK) begin
      reciprocal <= neg_o ? -sjd_pkg::RECIP_W'(pq[NS]) : sjd_pkg::RECIP_W'(pq[NS]);
    end else begin
      reciprocal <= '0;
    end
    if (p3d[NS]) begin
      measure <= neg_o ? -DW'(q6) : DW'(q6);
    end else begin
      measure <= DW'(pmag[NS] >> 1);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/sjd_checker.sv -----
// Port-level checker for the simplex Jacobian determinant unit, with its bind.
`default_nettype none
`include "simplex_jacobian_determinant_unit_defines.svh"
module sjd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic signed [sjd_pkg::DET_W-1:0]   determinant,
  input wire logic signed [sjd_pkg::RECIP_W-1:0] reciprocal,
  input wire logic [sjd_pkg::STAT_W-1:0]         status
);
  // an accepted element comes out after the fixed pipeline latency
  `SJD_ASSERT_IMPL(a_latency, start && !busy, ##68 done)
  // singular and bad-dimension results carry a zero reciprocal
  `SJD_ASSERT_IMPL(a_recip_zero, done && status != sjd_pkg::ST_OK, reciprocal == '0)
  // an ok result carries a nonzero determinant
  `SJD_ASSERT_IMPL(a_det_zero, done && status == sjd_pkg::ST_OK, determinant != '0)
  // reciprocal sign follows the determinant sign
  `SJD_ASSERT_IMPL(a_sign, done && status == sjd_pkg::ST_OK,
    reciprocal[sjd_pkg::RECIP_W-1] == determinant[sjd_pkg::DET_W-1])
endmodule

bind simplex_jacobian_determinant_unit sjd_checker u_sjd_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .determinant(determinant), .reciprocal(reciprocal), .status(status)
);
`default_nettype wire

// ----- bench/tb_simplex_jacobian_determinant_unit.sv -----
// Self-checking testbench for the simplex Jacobian determinant unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_simplex_jacobian_determinant_unit;
  localparam int SETTLE_CYCLES = 80;       // beyond the pipeline depth
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 150;

  typedef logic [11:0][15:0] element_t;

  typedef struct {
    logic signed [sjd_pkg::DET_W-1:0]   det;
    logic signed [sjd_pkg::RECIP_W-1:0] recip;
    logic signed [sjd_pkg::DET_W-1:0]   meas;
    logic [sjd_pkg::STAT_W-1:0]         status;
  } jacobian_t;

  typedef struct {
    logic [sjd_pkg::DIM_W-1:0] dim;
    element_t         elem;
    bit               typed;
    jacobian_t        want;
  } vector_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sjd_pkg::DIM_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  element_t coords = '0;
  logic done;
  logic signed [sjd_pkg::DET_W-1:0]   determinant;
  logic signed [sjd_pkg::RECIP_W-1:0] reciprocal;
  logic signed [sjd_pkg::DET_W-1:0]   measure;
  logic [sjd_pkg::STAT_W-1:0]         status;

  jacobian_t   expected_q[$];
  vector_row_t vectors[$];
  logic [sjd_pkg::DIM_W-1:0] dim_shadow = sjd_pkg::DIM_RESET;
  int unsigned cycles = 0, mismatches = 0, checked = 0;
  int unsigned n_singular = 0, n_bad_dim = 0, n_ok = 0;

  always #6 clk = ~clk;

  simplex_jacobian_determinant_unit i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .v1_x(coords[0]), .v1_y(coords[1]), .v1_z(coords[2]),
    .v2_x(coords[3]), .v2_y(coords[4]), .v2_z(coords[5]),
    .v3_x(coords[6]), .v3_y(coords[7]), .v3_z(coords[8]),
    .v4_x(coords[9]), .v4_y(coords[10]), .v4_z(coords[11]),
    .done(done), .determinant(determinant), .reciprocal(reciprocal),
    .measure(measure), .status(status)
  );

  // Determinant, reciprocal and measure of one element under a given dimension
  function automatic jacobian_t jacobian_of(input element_t e,
                                            input logic [sjd_pkg::DIM_W-1:0] d);
    jacobian_t r;
    longint ax, ay, az, bx, by, bz, dx, dy, dz, det;
    longint unsigned mag, q;
    ax = longint'($signed(e[3])) - longint'($signed(e[0]));
    ay = longint'($signed(e[4])) - longint'($signed(e[1]));
    az = longint'($signed(e[5])) - longint'($signed(e[2]));
    bx = longint'($signed(e[6])) - longint'($signed(e[0]));
    by = longint'($signed(e[7])) - longint'($signed(e[1]));
    bz = longint'($signed(e[8])) - longint'($signed(e[2]));
    dx = longint'($signed(e[9])) - longint'($signed(e[0]));
    dy = longint'($signed(e[10])) - longint'($signed(e[1]));
    dz = longint'($signed(e[11])) - longint'($signed(e[2]));
    r.det = '0; r.recip = '0; r.meas = '0; r.status = sjd_pkg::ST_OK;
    if (d == sjd_pkg::DIM_TRI) begin
      det = ax * by - bx * ay;
    end else if (d == sjd_pkg::DIM_TET) begin
      det = ax * by * dz + bx * dy * az + ay * bz * dx
          - az * by * dx - ay * bx * dz - ax * bz * dy;
    end else begin
      r.status = sjd_pkg::ST_BAD_DIM;
      return r;
    end
    mag = (det < 0) ? longint'(-det) : longint'(det);
    r.det = det[sjd_pkg::DET_W-1:0];
    if (d == sjd_pkg::DIM_TRI) begin
      r.meas = sjd_pkg::DET_W'(mag >> 1);
    end else begin
      r.meas = sjd_pkg::DET_W'((det < 0) ? -longint'(mag / 6) : longint'(mag / 6));
    end
    if (det == 0) begin
      r.status = sjd_pkg::ST_SINGULAR;
    end else begin
      q = 64'h4000_0000_0000_0000 / mag;
      r.recip = (det < 0) ? -longint'(q) : longint'(q);
    end
    return r;
  endfunction

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               expected_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin
    jacobian_t w;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result at cycle %0d", cycles);
      end else begin
        w = expected_q.pop_front();
        checked++;
        if (status == sjd_pkg::ST_SINGULAR) n_singular++;
        else if (status == sjd_pkg::ST_BAD_DIM) n_bad_dim++;
        else n_ok++;
        if (determinant !== w.det || reciprocal !== w.recip ||
            measure !== w.meas || status !== w.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch #%0d: det %0d/%0d recip %0d/%0d meas %0d/%0d st %0d/%0d",
                     checked, w.det, determinant, w.recip, reciprocal,
                     w.meas, measure, w.status, status);
        end
      end
    end
  end

  // One transfer on the command port; gaps inserted at random when enabled
  task automatic send_element(input element_t e, input bit gaps, input bit typed,
                              input jacobian_t want);
    bit taken;
    jacobian_t w;
    taken = 0;
    while (!taken) begin
      if (gaps && $urandom_range(99) < 36) begin
        start = 1'b0;
        @(negedge clk);
      end else begin
        coords = e;
        start = 1'b1;
        @(posedge clk);
        if (!busy) begin
          taken = 1;
          w = typed ? want : jacobian_of(e, dim_shadow);
          expected_q = {expected_q, w};
        end
        @(negedge clk);
      end
    end
  endtask

  // Hold off until the pipeline is empty
  task automatic drain();
    start = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_dimension(input logic [sjd_pkg::DIM_W-1:0] d);
    cfg_data = d;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    dim_shadow = d;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_vector(input logic [sjd_pkg::DIM_W-1:0] d, input element_t e,
                            input bit typed,
                            input longint det, input longint recip, input longint meas,
                            input logic [sjd_pkg::STAT_W-1:0] st);
    vector_row_t v;
    v.dim = d; v.elem = e; v.typed = typed;
    v.want.det = det[sjd_pkg::DET_W-1:0]; v.want.recip = recip;
    v.want.meas = meas[sjd_pkg::DET_W-1:0]; v.want.status = st;
    vectors = {vectors, v};
  endtask

  function automatic logic [15:0] rand_extreme();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'h0001;
    endcase
  endfunction

  // Random element: wide noise, clustered, degenerate and extreme shapes
  function automatic element_t rand_element();
    element_t e;
    int mode;
    logic [15:0] base;
    mode = $urandom_range(9);
    for (int i = 0; i < 12; i++) e[i] = 16'($urandom);
    if (mode == 5 || mode == 6 || mode == 9) begin
      for (int i = 0; i < 3; i++) begin
        base = 16'($urandom);
        for (int k = 0; k < 4; k++)
          e[k*3+i] = 16'(base + ((mode == 9) ? $urandom_range(4) - 2
                                             : $urandom_range(512) - 256));
      end
    end else if (mode == 7) begin
      case ($urandom_range(2))
        0: for (int i = 0; i < 3; i++) e[3+i] = e[i];
        1: for (int i = 0; i < 3; i++) e[6+i] = e[3+i];
        default: for (int i = 0; i < 3; i++) e[9+i] = e[$urandom_range(1)*3+i];
      endcase
    end else if (mode == 8) begin
      for (int i = 0; i < 12; i++) e[i] = rand_extreme();
    end
    return e;
  endfunction

  initial begin
    logic [sjd_pkg::DIM_W-1:0] phase_dims[12];
    jacobian_t none;
    phase_dims = '{sjd_pkg::DIM_TET, 2'd0, 2'd1, sjd_pkg::DIM_TRI, sjd_pkg::DIM_TET,
                   sjd_pkg::DIM_TRI, sjd_pkg::DIM_TET, sjd_pkg::DIM_TET, sjd_pkg::DIM_TRI,
                   2'd1, sjd_pkg::DIM_TET, sjd_pkg::DIM_TRI};
    none = '{default: '0};

    // Directed vectors, grouped by dimension; reset value 2 is used first
    add_vector(sjd_pkg::DIM_TRI, '0, 1, 0, 0, 0, sjd_pkg::ST_SINGULAR);
    add_vector(sjd_pkg::DIM_TRI, {64'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 48'h0}, 1,
               65536, 64'sh0000_4000_0000_0000, 32768, sjd_pkg::ST_OK);
    add_vector(sjd_pkg::DIM_TRI, {64'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001, 48'h0}, 1,
               1, 64'sh4000_0000_0000_0000, 0, sjd_pkg::ST_OK);
    add_vector(sjd_pkg::DIM_TRI, {64'h0, 16'h0, 16'h0001, 16'h0, 16'h0001, 16'h0, 48'h0}, 1,
               -1, -64'sh4000_0000_0000_0000, 0, sjd_pkg::ST_OK);
    add_vector(sjd_pkg::DIM_TRI, {48'h0, 16'h7fff, 16'h0, 16'h8000, 16'h8000,
                         16'h8000, 16'h7fff, 16'h0, 16'h8000, 16'h8000}, 0, 0, 0, 0, 0);
    add_vector(sjd_pkg::DIM_TRI, {48'h7fff_7fff_7fff, 48'h8000_8000_8000, 48'h7fff_7fff_7fff,
                         48'h8000_8000_8000}, 0, 0, 0, 0, 0);
    add_vector(sjd_pkg::DIM_TRI, {192{1'b1}}, 1, 0, 0, 0, sjd_pkg::ST_SINGULAR);
    add_vector(sjd_pkg::DIM_TET, '0, 1, 0, 0, 0, sjd_pkg::ST_SINGULAR);
    add_vector(sjd_pkg::DIM_TET,
               {16'h0001, 32'h0, 16'h0, 16'h0001, 16'h0, 32'h0, 16'h0001, 48'h0},
               1, 1, 64'sh4000_0000_0000_0000, 0, sjd_pkg::ST_OK);
    add_vector(sjd_pkg::DIM_TET,
               {16'h0001, 32'h0, 32'h0, 16'h0001, 16'h0, 16'h0001, 16'h0, 48'h0},
               1, -1, -64'sh4000_0000_0000_0000, 0, sjd_pkg::ST_OK);
    add_vector(sjd_pkg::DIM_TET,
               {16'hffff, 32'h0, 16'h0, 16'h0001, 16'h0, 32'h0, 16'h0006, 48'h0},
               0, 0, 0, 0, 0);
    add_vector(sjd_pkg::DIM_TET, {16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                         16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000},
               0, 0, 0, 0, 0);
    add_vector(sjd_pkg::DIM_TET, {16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                         16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff},
               0, 0, 0, 0, 0);
    add_vector(sjd_pkg::DIM_TET, {192{1'b1}}, 1, 0, 0, 0, sjd_pkg::ST_SINGULAR);
    add_vector(2'd0, {48'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001, 48'h0},
               1, 0, 0, 0, sjd_pkg::ST_BAD_DIM);
    add_vector(2'd0, {192{1'b1}}, 1, 0, 0, 0, sjd_pkg::ST_BAD_DIM);
    add_vector(2'd1, {16'h0001, 32'h0, 16'h0, 16'h0001, 16'h0, 32'h0, 16'h0001, 48'h0},
               1, 0, 0, 0, sjd_pkg::ST_BAD_DIM);
    add_vector(2'd1, {96'h7fff_8000_7fff_8000_7fff_8000, 96'h8000_7fff_8000_7fff_8000_7fff},
               1, 0, 0, 0, sjd_pkg::ST_BAD_DIM);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (vectors[i]) begin
      if (vectors[i].dim != dim_shadow) begin
        drain();
        write_dimension(vectors[i].dim);
      end
      send_element(vectors[i].elem, 1'b0, vectors[i].typed, vectors[i].want);
    end

    // Random phases; each drains before the dimension changes, one runs gap-free
    foreach (phase_dims[p]) begin
      drain();
      write_dimension(phase_dims[p]);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_element(rand_element(), p != 6, 1'b0, none);
    end

    drain();
    $display("Checked %0d elements: %0d regular, %0d singular, %0d bad dimension,",
             checked, n_ok, n_singular, n_bad_dim);
    $display("across triangle, tetrahedron and invalid dimension settings.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Failures: %0d mismatches, %0d results missing", mismatches,
               expected_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/sjd_pkg.sv
rtl/core/simplex_jacobian_determinant_unit.sv
rtl/core/sjd_checker.sv
bench/tb_simplex_jacobian_determinant_unit.sv
